// ===== hw/rtl/rtch_pkg.sv =====
// Shared types, widths and codes for the ray/triangle closest-hit block.
// Used by rtch_ctrl, rtch_dp and ray_triangle_closest_hit_top; no dependencies.
package rtch_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int COORD_W    = 32;   // vertex, origin and direction coordinates
   localparam int EDGE_W     = 33;   // edge and origin offset vectors
   localparam int PQ_W       = 66;   // cross products p and q
   localparam int LIMB_W     = 33;   // low limb of a cross product
   localparam int MUL_W      = 34;   // multiplier operand width
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ACC_W      = 101;  // det, u, v and t numerators
   localparam int T_W        = 31;
   localparam int TMIN_W     = 17;
   localparam int EPS_W      = 41;
   localparam int MESH_W     = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 41;
   localparam int DIV_CNT_W  = 5;
   localparam int DIV_STEPS  = T_W;

   localparam logic [T_W-1:0]    T_SAT       = '1;
   localparam logic [1:0]        AXIS_LAST   = 2'd2;
   localparam logic [EPS_W-1:0]  EPS_RESET   = 41'd28147498;
   localparam logic [TMIN_W-1:0] TMIN_RESET  = 17'd7;
   localparam logic [COORD_W-1:0] DIR_Z_RESET = 32'd65536;

   localparam logic [CSR_IDX_W-1:0] CSR_ORG_X = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORG_Y = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORG_Z = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_EPS   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TMIN  = 4'd7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL1, ST_BUBBLE, ST_MUL2, ST_FLUSH, ST_NORM, ST_CHECK, ST_DIV, ST_UPDATE
   } state_type;

   typedef enum logic [2:0] {
      DP_NOP, DP_LOAD, DP_MAC, DP_NORM, DP_CHECK, DP_DIV, DP_UPDATE
   } dp_op_type;

   typedef enum logic [1:0] {ASRC_D, ASRC_S, ASRC_P, ASRC_Q} a_src_type;
   typedef enum logic [1:0] {BSRC_E1, BSRC_E2, BSRC_S, BSRC_D} b_src_type;
   typedef enum logic [2:0] {DST_P, DST_Q, DST_DET, DST_U, DST_V, DST_T} dest_type;

   typedef struct packed {
      dp_op_type op;
      a_src_type a_src;
      logic [1:0] a_idx;
      logic a_hi;
      b_src_type b_src;
      logic [1:0] b_idx;
      logic neg;
      logic clear;
      logic wr;
      dest_type dest;
      logic [1:0] dest_idx;
   } cmd_type;

   typedef struct packed {
      logic reject;
      logic last;
      logic rsp_busy;
   } status_type;

   function automatic logic [1:0] axis_next(input logic [1:0] i);
      logic [1:0] r;
      unique case (i)
         2'd0: r = 2'd1;
         2'd1: r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] axis_prev(input logic [1:0] i);
      logic [1:0] r;
      unique case (i)
         2'd0: r = 2'd2;
         2'd1: r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/ray_triangle_closest_hit_top.sv =====
// Each triangle transaction runs a double-sided Moller-Trumbore test against the ray held
// in the csr_ registers and keeps the closest hit; the triangle flagged last_triangle
// produces one rsp_ transaction and clears the scene. No new triangle is accepted until
// the current one is through: the single shared 34x34 multiplier builds the exact cross
// and dot products, and a triangle that passes the checks then goes through the
// bit-serial restoring divider before the update.
// A last triangle also waits while the previous scene result is still held on rsp_.
// Depends on rtch_pkg, rtch_ctrl and rtch_dp.
module ray_triangle_closest_hit_top #(
   parameter int FRAC_BITS = rtch_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rtch_pkg::COORD_W-1:0] req_va_x,
   input  logic signed [rtch_pkg::COORD_W-1:0] req_va_y,
   input  logic signed [rtch_pkg::COORD_W-1:0] req_va_z,
   input  logic signed [rtch_pkg::COORD_W-1:0] req_vb_x,
   input  logic signed [rtch_pkg::COORD_W-1:0] req_vb_y,
   input  logic signed [rtch_pkg::COORD_W-1:0] req_vb_z,
   input  logic signed [rtch_pkg::COORD_W-1:0] req_vc_x,
   input  logic signed [rtch_pkg::COORD_W-1:0] req_vc_y,
   input  logic signed [rtch_pkg::COORD_W-1:0] req_vc_z,
   input  logic [rtch_pkg::MESH_W-1:0]         req_mesh_id,
   input  logic                                req_last_triangle,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit_found,
   output logic [rtch_pkg::T_W-1:0]            rsp_closest_t,
   output logic [rtch_pkg::MESH_W-1:0]         rsp_closest_mesh,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rtch_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rtch_pkg::CSR_DATA_W-1:0]     csr_data
);

   rtch_pkg::cmd_type    ctl_cmd;
   rtch_pkg::status_type dp_sts;
   logic signed [rtch_pkg::COORD_W-1:0] va [3];
   logic signed [rtch_pkg::COORD_W-1:0] vb [3];
   logic signed [rtch_pkg::COORD_W-1:0] vc [3];

   assign va[0] = req_va_x;
   assign va[1] = req_va_y;
   assign va[2] = req_va_z;
   assign vb[0] = req_vb_x;
   assign vb[1] = req_vb_y;
   assign vb[2] = req_vb_z;
   assign vc[0] = req_vc_x;
   assign vc[1] = req_vc_y;
   assign vc[2] = req_vc_z;

   rtch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (dp_sts),
      .cmd       (ctl_cmd)
   );

   rtch_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctl_cmd),
      .sts              (dp_sts),
      .va               (va),
      .vb               (vb),
      .vc               (vc),
      .mesh_id          (req_mesh_id),
      .last_triangle    (req_last_triangle),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit_found    (rsp_hit_found),
      .rsp_closest_t    (rsp_closest_t),
      .rsp_closest_mesh (rsp_closest_mesh)
   );

`ifndef NO_ASSERTIONS
   // An accepted triangle starts the multiply sequence in the next cycle.
   a_accept_starts_mac: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (ctl_cmd.op == rtch_pkg::DP_MAC))
      else $error("accepted triangle did not start the multiply sequence");

   // No triangle is taken while the multiplier is busy.
   a_no_accept_in_mac: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.op == rtch_pkg::DP_MAC) |-> req_stall)
      else $error("input accepted during the multiply sequence");

   // A result appears only after the update of a last triangle.
   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctl_cmd.op == rtch_pkg::DP_UPDATE && dp_sts.last))
      else $error("result raised without a last-triangle update");
`endif

endmodule

// ===== hw/rtl/rtch_ctrl.sv =====
// Sequencer of the ray/triangle closest-hit block: walks the multiply steps,
// the checks, the divide and the update. Depends on rtch_pkg.
module rtch_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rtch_pkg::status_type sts,
   output rtch_pkg::cmd_type    cmd
);

   rtch_pkg::state_type state_ff, state_in;
   logic [1:0] cnt_grp_ff, cnt_grp_in;
   logic [1:0] cnt_idx_ff, cnt_idx_in;
   logic       cnt_bit_ff, cnt_bit_in;
   logic [rtch_pkg::DIV_CNT_W-1:0] cnt_div_ff, cnt_div_in;
   logic       last_mul;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rtch_pkg::ST_IDLE;
         cnt_grp_ff <= '0;
         cnt_idx_ff <= '0;
         cnt_bit_ff <= 1'b0;
         cnt_div_ff <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_grp_ff <= cnt_grp_in;
         cnt_idx_ff <= cnt_idx_in;
         cnt_bit_ff <= cnt_bit_in;
         cnt_div_ff <= cnt_div_in;
      end
   end

   assign req_stall = (state_ff != rtch_pkg::ST_IDLE);
   assign last_mul  = (cnt_idx_ff == rtch_pkg::AXIS_LAST) && cnt_bit_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_grp_in = cnt_grp_ff;
      cnt_idx_in = cnt_idx_ff;
      cnt_bit_in = cnt_bit_ff;
      cnt_div_in = cnt_div_ff;

      cmd.op       = rtch_pkg::DP_NOP;
      cmd.a_src    = rtch_pkg::ASRC_D;
      cmd.a_idx    = cnt_idx_ff;
      cmd.a_hi     = 1'b0;
      cmd.b_src    = rtch_pkg::BSRC_E1;
      cmd.b_idx    = cnt_idx_ff;
      cmd.neg      = 1'b0;
      cmd.clear    = 1'b0;
      cmd.wr       = 1'b0;
      cmd.dest     = rtch_pkg::DST_P;
      cmd.dest_idx = cnt_idx_ff;

      // Step counters advance through terms, then axes, then result groups.
      if (state_ff == rtch_pkg::ST_MUL1 || state_ff == rtch_pkg::ST_MUL2) begin
         if (cnt_bit_ff) begin
            cnt_bit_in = 1'b0;
            if (cnt_idx_ff == rtch_pkg::AXIS_LAST) begin
               cnt_idx_in = 2'd0;
               cnt_grp_in = cnt_grp_ff + 2'd1;
            end else begin
               cnt_idx_in = cnt_idx_ff + 2'd1;
            end
         end else begin
            cnt_bit_in = 1'b1;
         end
      end

      unique case (state_ff)
         rtch_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op     = rtch_pkg::DP_LOAD;
               state_in   = rtch_pkg::ST_MUL1;
               cnt_grp_in = '0;
               cnt_idx_in = '0;
               cnt_bit_in = 1'b0;
            end
         end
         rtch_pkg::ST_MUL1: begin
            // Cross products: each axis is one product minus another.
            cmd.op    = rtch_pkg::DP_MAC;
            cmd.a_idx = cnt_bit_ff ? rtch_pkg::axis_prev(cnt_idx_ff)
                                   : rtch_pkg::axis_next(cnt_idx_ff);
            cmd.b_idx = cnt_bit_ff ? rtch_pkg::axis_next(cnt_idx_ff)
                                   : rtch_pkg::axis_prev(cnt_idx_ff);
            cmd.neg   = cnt_bit_ff;
            cmd.clear = !cnt_bit_ff;
            cmd.wr    = cnt_bit_ff;
            if (cnt_grp_ff == 2'd0) begin
               cmd.a_src = rtch_pkg::ASRC_D;
               cmd.b_src = rtch_pkg::BSRC_E2;
               cmd.dest  = rtch_pkg::DST_P;
            end else begin
               cmd.a_src = rtch_pkg::ASRC_S;
               cmd.b_src = rtch_pkg::BSRC_E1;
               cmd.dest  = rtch_pkg::DST_Q;
            end
            if (cnt_grp_ff == 2'd1 && last_mul) begin
               state_in   = rtch_pkg::ST_BUBBLE;
               cnt_grp_in = '0;
            end
         end
         rtch_pkg::ST_BUBBLE: begin
            state_in = rtch_pkg::ST_MUL2;
         end
         rtch_pkg::ST_MUL2: begin
            // Dot products: each axis takes a low limb and a high limb.
            cmd.op    = rtch_pkg::DP_MAC;
            cmd.a_hi  = cnt_bit_ff;
            cmd.clear = (cnt_idx_ff == 2'd0) && !cnt_bit_ff;
            cmd.wr    = last_mul;
            unique case (cnt_grp_ff)
               2'd0: begin
                  cmd.a_src = rtch_pkg::ASRC_P;
                  cmd.b_src = rtch_pkg::BSRC_E1;
                  cmd.dest  = rtch_pkg::DST_DET;
               end
               2'd1: begin
                  cmd.a_src = rtch_pkg::ASRC_P;
                  cmd.b_src = rtch_pkg::BSRC_S;
                  cmd.dest  = rtch_pkg::DST_U;
               end
               2'd2: begin
                  cmd.a_src = rtch_pkg::ASRC_Q;
                  cmd.b_src = rtch_pkg::BSRC_D;
                  cmd.dest  = rtch_pkg::DST_V;
               end
               default: begin
                  cmd.a_src = rtch_pkg::ASRC_Q;
                  cmd.b_src = rtch_pkg::BSRC_E2;
                  cmd.dest  = rtch_pkg::DST_T;
               end
            endcase
            if (cnt_grp_ff == 2'd3 && last_mul) begin
               state_in = rtch_pkg::ST_FLUSH;
            end
         end
         rtch_pkg::ST_FLUSH: begin
            state_in = rtch_pkg::ST_NORM;
         end
         rtch_pkg::ST_NORM: begin
            cmd.op   = rtch_pkg::DP_NORM;
            state_in = rtch_pkg::ST_CHECK;
         end
         rtch_pkg::ST_CHECK: begin
            cmd.op     = rtch_pkg::DP_CHECK;
            cnt_div_in = '0;
            state_in   = sts.reject ? rtch_pkg::ST_UPDATE : rtch_pkg::ST_DIV;
         end
         rtch_pkg::ST_DIV: begin
            cmd.op     = rtch_pkg::DP_DIV;
            cnt_div_in = cnt_div_ff + rtch_pkg::DIV_CNT_W'(1);
            if (cnt_div_ff == rtch_pkg::DIV_CNT_W'(rtch_pkg::DIV_STEPS - 1)) begin
               state_in = rtch_pkg::ST_UPDATE;
            end
         end
         rtch_pkg::ST_UPDATE: begin
            // A scene result waits here while the previous one is still held.
            if (!(sts.last && sts.rsp_busy)) begin
               cmd.op   = rtch_pkg::DP_UPDATE;
               state_in = rtch_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rtch_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/rtch_dp.sv =====
// Datapath of the ray/triangle closest-hit block: ray registers, shared
// multiplier with accumulator, checks, restoring divider, result register.
// Depends on rtch_pkg.
module rtch_dp #(
   parameter int FRAC_BITS = rtch_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rtch_pkg::cmd_type                      cmd,
   output rtch_pkg::status_type                   sts,
   input  logic signed [rtch_pkg::COORD_W-1:0]    va [3],
   input  logic signed [rtch_pkg::COORD_W-1:0]    vb [3],
   input  logic signed [rtch_pkg::COORD_W-1:0]    vc [3],
   input  logic [rtch_pkg::MESH_W-1:0]            mesh_id,
   input  logic                                   last_triangle,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rtch_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rtch_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_hit_found,
   output logic [rtch_pkg::T_W-1:0]               rsp_closest_t,
   output logic [rtch_pkg::MESH_W-1:0]            rsp_closest_mesh
);

   localparam int ACC_W   = rtch_pkg::ACC_W;
   localparam int T_W     = rtch_pkg::T_W;
   localparam int T_SHIFT = T_W - FRAC_BITS;
   localparam int PQ_W    = rtch_pkg::PQ_W;
   localparam int LIMB_W  = rtch_pkg::LIMB_W;
   localparam int MUL_W   = rtch_pkg::MUL_W;

   logic signed [rtch_pkg::COORD_W-1:0] org_ff [3];
   logic signed [rtch_pkg::COORD_W-1:0] dir_ff [3];
   logic [rtch_pkg::EPS_W-1:0]  eps_ff;
   logic [rtch_pkg::TMIN_W-1:0] tmin_ff;

   logic signed [rtch_pkg::EDGE_W-1:0] e1_ff [3];
   logic signed [rtch_pkg::EDGE_W-1:0] e2_ff [3];
   logic signed [rtch_pkg::EDGE_W-1:0] s_ff  [3];
   logic [rtch_pkg::MESH_W-1:0] mesh_ff;
   logic                        last_ff;

   logic signed [PQ_W-1:0] p_ff [3];
   logic signed [PQ_W-1:0] q_ff [3];

   logic signed [MUL_W-1:0]  opa, opb;
   logic signed [rtch_pkg::PROD_W-1:0] prod_in, prod_ff;
   logic        mac_vld_ff, mac_neg_ff, mac_clear_ff, mac_hi_ff, mac_wr_ff;
   rtch_pkg::dest_type mac_dest_ff;
   logic [1:0]  mac_didx_ff;

   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_base, term;
   logic signed [ACC_W-1:0] det_ff, u_ff, v_ff, t_ff;

   logic signed [ACC_W-1:0] eps_ext;
   logic signed [ACC_W:0]   uv_sum;
   logic                    reject;
   logic [ACC_W+T_SHIFT-1:0] det_sh, t_ext;

   logic [ACC_W-1:0] rem_ff;
   logic [T_W-1:0]   nlow_ff, quot_ff;
   logic             sat_ff, pass_ff;
   logic [ACC_W:0]   trial;
   logic             trial_ge;

   logic [T_W-1:0]   best_ff, best_n, t_val;
   logic [rtch_pkg::MESH_W-1:0] bmesh_ff, bmesh_n;
   logic             any_ff, any_n, hit, better;
   logic             rsp_valid_ff, rsp_hit_ff;
   logic [T_W-1:0]   rsp_t_ff;
   logic [rtch_pkg::MESH_W-1:0] rsp_mesh_ff;

   // Configuration registers; the user must write them only while the block is idle, as the block does not enforce it.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= $signed(rtch_pkg::DIR_Z_RESET);
         eps_ff    <= rtch_pkg::EPS_RESET;
         tmin_ff   <= rtch_pkg::TMIN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            rtch_pkg::CSR_ORG_X: org_ff[0] <= $signed(csr_data[rtch_pkg::COORD_W-1:0]);
            rtch_pkg::CSR_ORG_Y: org_ff[1] <= $signed(csr_data[rtch_pkg::COORD_W-1:0]);
            rtch_pkg::CSR_ORG_Z: org_ff[2] <= $signed(csr_data[rtch_pkg::COORD_W-1:0]);
            rtch_pkg::CSR_DIR_X: dir_ff[0] <= $signed(csr_data[rtch_pkg::COORD_W-1:0]);
            rtch_pkg::CSR_DIR_Y: dir_ff[1] <= $signed(csr_data[rtch_pkg::COORD_W-1:0]);
            rtch_pkg::CSR_DIR_Z: dir_ff[2] <= $signed(csr_data[rtch_pkg::COORD_W-1:0]);
            rtch_pkg::CSR_EPS:   eps_ff    <= csr_data[rtch_pkg::EPS_W-1:0];
            rtch_pkg::CSR_TMIN:  tmin_ff   <= csr_data[rtch_pkg::TMIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Triangle load: edges and origin offset are formed on the way in.
   always_ff @(posedge clock) begin
      if (cmd.op == rtch_pkg::DP_LOAD) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= $signed({vb[i][rtch_pkg::COORD_W-1], vb[i]})
                      - $signed({va[i][rtch_pkg::COORD_W-1], va[i]});
            e2_ff[i] <= $signed({vc[i][rtch_pkg::COORD_W-1], vc[i]})
                      - $signed({va[i][rtch_pkg::COORD_W-1], va[i]});
            s_ff[i]  <= $signed({org_ff[i][rtch_pkg::COORD_W-1], org_ff[i]})
                      - $signed({va[i][rtch_pkg::COORD_W-1], va[i]});
         end
         mesh_ff <= mesh_id;
         last_ff <= last_triangle;
      end
   end

   // Operand selection. Wide cross products enter as an unsigned low limb
   // and a signed high limb.
   always_comb begin
      unique case (cmd.a_src)
         rtch_pkg::ASRC_D: opa = MUL_W'(dir_ff[cmd.a_idx]);
         rtch_pkg::ASRC_S: opa = MUL_W'(s_ff[cmd.a_idx]);
         rtch_pkg::ASRC_P: opa = cmd.a_hi
            ? MUL_W'($signed(p_ff[cmd.a_idx][PQ_W-1:LIMB_W]))
            : $signed(MUL_W'(p_ff[cmd.a_idx][LIMB_W-1:0]));
         default: opa = cmd.a_hi
            ? MUL_W'($signed(q_ff[cmd.a_idx][PQ_W-1:LIMB_W]))
            : $signed(MUL_W'(q_ff[cmd.a_idx][LIMB_W-1:0]));
      endcase
      unique case (cmd.b_src)
         rtch_pkg::BSRC_E1: opb = MUL_W'(e1_ff[cmd.b_idx]);
         rtch_pkg::BSRC_E2: opb = MUL_W'(e2_ff[cmd.b_idx]);
         rtch_pkg::BSRC_S:  opb = MUL_W'(s_ff[cmd.b_idx]);
         default:           opb = MUL_W'(dir_ff[cmd.b_idx]);
      endcase
   end

   assign prod_in = opa * opb;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_vld_ff <= 1'b0;
      end else begin
         mac_vld_ff <= (cmd.op == rtch_pkg::DP_MAC);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      mac_neg_ff   <= cmd.neg;
      mac_clear_ff <= cmd.clear;
      mac_hi_ff    <= cmd.a_hi;
      mac_wr_ff    <= cmd.wr;
      mac_dest_ff  <= cmd.dest;
      mac_didx_ff  <= cmd.dest_idx;
   end

   always_comb begin
      term     = mac_hi_ff ? (ACC_W'(prod_ff) <<< LIMB_W) : ACC_W'(prod_ff);
      acc_base = mac_clear_ff ? '0 : acc_ff;
      acc_in   = mac_neg_ff ? (acc_base - term) : (acc_base + term);
   end

   // Accumulate stage, then normalize the sign of the determinant, negating u, v and t with it.
   always_ff @(posedge clock) begin
      if (mac_vld_ff) begin
         acc_ff <= acc_in;
         if (mac_wr_ff) begin
            unique case (mac_dest_ff)
               rtch_pkg::DST_P:   p_ff[mac_didx_ff] <= acc_in[PQ_W-1:0];
               rtch_pkg::DST_Q:   q_ff[mac_didx_ff] <= acc_in[PQ_W-1:0];
               rtch_pkg::DST_DET: det_ff <= acc_in;
               rtch_pkg::DST_U:   u_ff   <= acc_in;
               rtch_pkg::DST_V:   v_ff   <= acc_in;
               default:           t_ff   <= acc_in;
            endcase
         end
      end else if (cmd.op == rtch_pkg::DP_NORM && det_ff[ACC_W-1]) begin
         det_ff <= -det_ff;
         u_ff   <= -u_ff;
         v_ff   <= -v_ff;
         t_ff   <= -t_ff;
      end
   end

   always_comb begin
      eps_ext = $signed(ACC_W'(eps_ff));
      uv_sum  = (ACC_W + 1)'(u_ff) + (ACC_W + 1)'(v_ff);
      reject  = (det_ff == '0) || (det_ff < eps_ext)
             || u_ff[ACC_W-1] || (u_ff > det_ff)
             || v_ff[ACC_W-1] || (uv_sum > (ACC_W + 1)'(det_ff))
             || t_ff[ACC_W-1] || (t_ff == '0);
      // The quotient saturates when t >= det * 2^(31 - FRAC_BITS).
      det_sh  = {$unsigned(det_ff), {T_SHIFT{1'b0}}};
      t_ext   = (ACC_W + T_SHIFT)'($unsigned(t_ff));
      trial    = {rem_ff, nlow_ff[T_W-1]};
      trial_ge = (trial >= (ACC_W + 1)'($unsigned(det_ff)));
   end

   // Restoring divide of t * 2^FRAC_BITS by det, one quotient bit a cycle.
   always_ff @(posedge clock) begin
      if (cmd.op == rtch_pkg::DP_CHECK) begin
         pass_ff <= !reject;
         sat_ff  <= (t_ext >= det_sh);
         rem_ff  <= $unsigned(t_ff) >> T_SHIFT;
         nlow_ff <= {t_ff[T_SHIFT-1:0], {FRAC_BITS{1'b0}}};
         quot_ff <= '0;
      end else if (cmd.op == rtch_pkg::DP_DIV) begin
         rem_ff  <= trial_ge ? ACC_W'(trial - (ACC_W + 1)'($unsigned(det_ff)))
                             : ACC_W'(trial);
         nlow_ff <= nlow_ff << 1;
         quot_ff <= {quot_ff[T_W-2:0], trial_ge};
      end
   end

   always_comb begin
      t_val   = sat_ff ? rtch_pkg::T_SAT : quot_ff;
      hit     = pass_ff && (t_val > T_W'(tmin_ff));
      better  = hit && (!any_ff || (t_val < best_ff));
      best_n  = better ? t_val : best_ff;
      bmesh_n = better ? mesh_ff : bmesh_ff;
      any_n   = any_ff || hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= rtch_pkg::T_SAT;
         bmesh_ff     <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == rtch_pkg::DP_UPDATE) begin
            if (last_ff) begin
               best_ff  <= rtch_pkg::T_SAT;
               bmesh_ff <= '0;
               any_ff   <= 1'b0;
            end else begin
               best_ff  <= best_n;
               bmesh_ff <= bmesh_n;
               any_ff   <= any_n;
            end
         end
         if (cmd.op == rtch_pkg::DP_UPDATE && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == rtch_pkg::DP_UPDATE && last_ff) begin
         rsp_hit_ff  <= any_n;
         rsp_t_ff    <= best_n;
         rsp_mesh_ff <= any_n ? bmesh_n : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_found    = rsp_hit_ff;
   assign rsp_closest_t    = rsp_t_ff;
   assign rsp_closest_mesh = rsp_mesh_ff;

   assign sts.reject   = reject;
   assign sts.last     = last_ff;
   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;

endmodule
